[rtl/lifo_stack_allocator_assert.svh]
// ---------------------------------------------------------------------------
// LIFO stack allocator assertion macros
// Clocked property checks. In synthesis they expand to nothing.
// ---------------------------------------------------------------------------
`ifndef LIFO_STACK_ALLOCATOR_ASSERT_SVH
`define LIFO_STACK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// check on every edge outside reset
`define LSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check on every edge, reset included
`define LSA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LSA_ASSERT(label, prop, msg)
`define LSA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/lsa_pkg.sv]
// ---------------------------------------------------------------------------
// LIFO stack allocator package
// Sizes, operation and status codes, and control types for the allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package lsa_pkg;

	// stack and alignment sizing (alignment must be a power of two)
	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned ALIGN_BYTES = 8;

	// field widths
	localparam int unsigned SIZE_W     = 32;
	localparam int unsigned HANDLE_W   = 4;
	localparam int unsigned DEPTH_W    = $clog2(STACK_DEPTH + 1);
	localparam int unsigned DEPTH_F_W  = 5;
	localparam int unsigned CMP_W      = (DEPTH_W > HANDLE_W) ? DEPTH_W : HANDLE_W;
	localparam int unsigned IN_W       = 40;
	localparam int unsigned OUT_W      = 80;
	localparam int unsigned OUT_USED_W = 2 + SIZE_W + SIZE_W + HANDLE_W + DEPTH_F_W;

	// clears the low bits of a rounded-up byte count
	localparam logic [SIZE_W:0] ALIGN_MASK = ~((SIZE_W + 1)'(ALIGN_BYTES - 1));

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_CLEAR = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DEPTH = 2'd1,
		ST_NOMEM = 2'd2,
		ST_ORDER = 2'd3
	} status_t;

	// shift command for the row of entry cells
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctrl_t;

endpackage

`default_nettype wire

[rtl/lifo_stack_allocator.sv]
// Latency: a result is valid in the cycle after its request transfer.
// Throughput: one request per cycle while results are taken; the rate is set by
//   the single align-add and pool compare in front of the output register.
// Entry sizes live in a row of shift cells, top of stack in cell 0.
// Reset clears depth, used bytes, pool size and output valid; entry cells are
//   not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// LIFO stack allocator
// Aligned bump allocation over a byte pool with top-of-stack free and clear.
// ---------------------------------------------------------------------------
`default_nettype none

module lifo_stack_allocator
	import lsa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration: pool size in bytes
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [SIZE_W-1:0] cfg_data,
	// requests
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // func[1:0], byte_count[33:2], handle[37:34], zero
	// results
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata   // status[1:0], offset[33:2], alloc_size[65:34],
	                                        // entry_index[69:66], depth[74:70], zero
);

	logic [SIZE_W-1:0]  pool_q;
	logic [DEPTH_W-1:0] live_q;
	logic [SIZE_W-1:0]  used_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic [SIZE_W-1:0]  cell_size [STACK_DEPTH];
	shift_ctrl_t        shift;

	func_t              func;
	logic [SIZE_W-1:0]  byte_count;
	logic [HANDLE_W-1:0] handle;
	logic               accept;

	logic [SIZE_W:0]    rounded;
	logic [SIZE_W:0]    aligned;
	logic [SIZE_W:0]    required;
	logic               full;
	logic               no_room;
	logic               top_ok;

	status_t            status;
	logic [SIZE_W-1:0]  res_offset;
	logic [SIZE_W-1:0]  res_size;
	logic [HANDLE_W-1:0] res_index;
	logic [DEPTH_W-1:0] live_nxt;
	logic [SIZE_W-1:0]  used_nxt;

	// unpack the request
	assign func       = func_t'(s_tdata[1:0]);
	assign byte_count = s_tdata[2 +: SIZE_W];
	assign handle     = s_tdata[2 + SIZE_W +: HANDLE_W];

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	// round up to the alignment and check against the pool
	assign rounded  = {1'b0, byte_count} + (SIZE_W + 1)'(ALIGN_BYTES - 1);
	assign aligned  = rounded & ALIGN_MASK;
	assign required = {1'b0, used_q} + {1'b0, aligned[SIZE_W-1:0]};
	assign full     = (live_q == DEPTH_W'(STACK_DEPTH));
	assign no_room  = aligned[SIZE_W] || (required > {1'b0, pool_q});
	assign top_ok   = (live_q != '0) && (CMP_W'(handle) == CMP_W'(live_q - 1'b1));

	// decide the result and the next stack state
	always_comb begin
		status     = ST_OK;
		res_offset = '0;
		res_size   = '0;
		res_index  = '0;
		live_nxt   = live_q;
		used_nxt   = used_q;
		shift      = '0;
		unique case (func)
			FN_ALLOC: begin
				if (full) begin
					status = ST_DEPTH;
				end else if (no_room) begin
					status = ST_NOMEM;
				end else begin
					res_offset = used_q;
					res_size   = aligned[SIZE_W-1:0];
					res_index  = HANDLE_W'(live_q);
					live_nxt   = live_q + 1'b1;
					used_nxt   = required[SIZE_W-1:0];
					shift.push = 1'b1;
				end
			end
			FN_FREE: begin
				if (!top_ok) begin
					status = ST_ORDER;
				end else begin
					used_nxt   = used_q - cell_size[0];
					res_offset = used_nxt;
					res_size   = cell_size[0];
					res_index  = handle;
					live_nxt   = live_q - 1'b1;
					shift.pop  = 1'b1;
				end
			end
			FN_CLEAR: begin
				live_nxt = '0;
				used_nxt = '0;
			end
			FN_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// row of entry cells, top of stack at cell 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [SIZE_W-1:0] up_size;
		logic [SIZE_W-1:0] down_size;
		shift_ctrl_t       cell_ctrl;

		if (i == 0) begin : g_top
			assign up_size = aligned[SIZE_W-1:0];
		end else begin : g_mid
			assign up_size = cell_size[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign down_size = '0;
		end else begin : g_upper
			assign down_size = cell_size[i+1];
		end

		assign cell_ctrl.push = accept && shift.push;
		assign cell_ctrl.pop  = accept && shift.pop;

		lsa_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.up_size   (up_size),
			.down_size (down_size),
			.size      (cell_size[i])
		);
	end

	// hold pool size, depth and used bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= '0;
			live_q <= '0;
			used_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_q <= cfg_data;
			end
			if (accept) begin
				live_q <= live_nxt;
				used_q <= used_nxt;
			end
		end
	end

	// output valid: set on request transfer, drop once the result transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {(OUT_W - OUT_USED_W)'(0), DEPTH_F_W'(live_nxt), res_index,
				res_size, res_offset, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "lifo_stack_allocator_assert.svh"

	`LSA_ASSERT_ALWAYS(a_depth_bound, live_q <= DEPTH_W'(STACK_DEPTH), "stack depth out of range")
	`LSA_ASSERT(a_empty_no_bytes, (live_q == '0) |-> (used_q == '0), "bytes in use on empty stack")
	`LSA_ASSERT(a_push_depth, (accept && shift.push) |=> (live_q == $past(live_q) + 1'b1),
		"push did not deepen the stack")
	`LSA_ASSERT(a_stall_blocks, (m_tvalid_q && !m_tready) |-> !accept,
		"request taken while a result is stalled")

endmodule

`default_nettype wire

[rtl/lsa_cell.sv]
// ---------------------------------------------------------------------------
// LIFO stack allocator entry cell
// Holds one entry size; takes its upper neighbour on push, lower on pop.
// ---------------------------------------------------------------------------
`default_nettype none

module lsa_cell
	import lsa_pkg::*;
(
	input  wire logic              clk,
	input  wire shift_ctrl_t       ctrl,
	input  wire logic [SIZE_W-1:0] up_size,
	input  wire logic [SIZE_W-1:0] down_size,
	output logic      [SIZE_W-1:0] size
);

	logic [SIZE_W-1:0] size_q;

	// shift towards the bottom on push, towards the top on pop, else hold
	always_ff @(posedge clk) begin
		priority if (ctrl.push) begin
			size_q <= up_size;
		end else if (ctrl.pop) begin
			size_q <= down_size;
		end
	end

	assign size = size_q;

endmodule

`default_nettype wire
